[hw/rtl/hrld_pkg.sv]
// Package for the HTTP request line detector.
// Holds the character constants, the method spelling table and the item type.
// No dependencies.
`timescale 1ns / 1ps

package hrld_pkg;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  localparam int METHOD_COUNT = 7;
  localparam int POS_W        = 4;
  localparam int TLEN_W       = 3;

  localparam logic [POS_W-1:0]  POS_MAX       = 4'd15;
  localparam logic [TLEN_W-1:0] TOKEN_LEN_MAX = 3'd6;
  localparam logic [TLEN_W-1:0] VERSION_LEN   = 3'd5;
  localparam logic [METHOD_COUNT-1:0] ALL_METHODS = '1;

  // Method spellings, one row per method, padded with zero bytes.
  localparam logic [7:0] METHOD_TEXT [0:METHOD_COUNT-1][0:7] = '{
    '{"G", "E", "T", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"H", "E", "A", "D", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"P", "O", "S", "T", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"P", "U", "T", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"D", "E", "L", "E", "T", "E", 8'd0, 8'd0},
    '{"T", "R", "A", "C", "E", 8'd0, 8'd0, 8'd0},
    '{"C", "O", "N", "N", "E", "C", "T", 8'd0}
  };

  localparam logic [POS_W-1:0] METHOD_LEN [0:METHOD_COUNT-1] = '{
    4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7
  };

  localparam logic [7:0] VERSION_TEXT [0:4] = '{"H", "T", "T", "P", "/"};

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last_byte;
  } hrld_item_t;

endpackage

[hw/rtl/http_request_line_detector.sv]
// A byte transaction enters the input register at acceptance; the verdict of a line is
// registered in the output register as its last byte leaves the input register.
// Throughput: one byte per cycle, but a last byte waits while the output register is full and not drained.
// Reset (rst, synchronous, active high) empties both registers and returns the
// scan state to the start of a line. Depends on hrld_pkg and hrld_line_state.
`timescale 1ns / 1ps

module http_request_line_detector import hrld_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] line_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_request_line
);

  // Input register: holds one accepted byte transaction.
  hrld_item_t s1_item;
  logic       s1_valid;
  logic       s1_adv;
  logic       verdict;

  // The held byte moves on when it yields no result, or when the output
  // register is empty or being drained in this cycle.
  assign s1_adv   = s1_valid && (!s1_item.last_byte || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.line_byte <= line_byte;
      s1_item.last_byte <= last_byte;
    end
  end

  // The scan state advances exactly once per byte, when the byte leaves the
  // input register; the last byte of a line also clears it.
  hrld_line_state u_line_state (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_adv),
    .item    (s1_item),
    .verdict (verdict)
  );

  // Output register: one verdict per line, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item.last_byte) begin
      is_request_line <= verdict;
    end
  end

endmodule

[hw/rtl/hrld_line_state.sv]
// Per-line scan state of the HTTP request line detector.
// Tracks method matching and the last token; gives the verdict for the byte in hand.
// Depends on hrld_pkg.
`timescale 1ns / 1ps

module hrld_line_state import hrld_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  hrld_item_t item,
  output logic       verdict
);

  logic [POS_W-1:0]        byte_position;
  logic [METHOD_COUNT-1:0] method_candidates;
  logic                    method_found;
  logic                    token_present;
  logic                    token_at_start;
  logic [TLEN_W-1:0]       token_length;
  logic                    token_prefix_ok;
  logic                    previous_was_space;

  logic [POS_W-1:0]        byte_position_next;
  logic [METHOD_COUNT-1:0] method_candidates_next;
  logic                    method_found_next;
  logic                    token_present_next;
  logic                    token_at_start_next;
  logic [TLEN_W-1:0]       token_length_next;
  logic                    token_prefix_ok_next;
  logic                    previous_was_space_next;
  logic                    ws;

  assign ws = (item.line_byte == CHAR_TAB) || (item.line_byte == CHAR_SPACE);

  always_comb begin
    method_candidates_next = method_candidates;
    method_found_next      = method_found;
    // Each method is checked on its own; a candidate drops out on a mismatch
    // or once its spelling is complete.
    for (int n = 0; n < METHOD_COUNT; n++) begin
      if (method_candidates[n]) begin
        if (byte_position < METHOD_LEN[n]) begin
          if (item.line_byte != METHOD_TEXT[n][byte_position[2:0]]) begin
            method_candidates_next[n] = 1'b0;
          end
        end else begin
          if ((byte_position == METHOD_LEN[n]) && ws) begin
            method_found_next = 1'b1;
          end
          method_candidates_next[n] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    token_present_next      = token_present;
    token_at_start_next     = token_at_start;
    token_length_next       = token_length;
    token_prefix_ok_next    = token_prefix_ok;
    previous_was_space_next = previous_was_space;
    if (ws) begin
      previous_was_space_next = 1'b1;
    end else if (previous_was_space) begin
      previous_was_space_next = 1'b0;
      token_present_next      = 1'b1;
      token_at_start_next     = (byte_position == '0);
      token_length_next       = 3'd1;
      token_prefix_ok_next    = (item.line_byte == VERSION_TEXT[0]);
    end else begin
      if (token_length < VERSION_LEN) begin
        token_prefix_ok_next = token_prefix_ok &&
                               (item.line_byte == VERSION_TEXT[token_length]);
      end
      if (token_length < TOKEN_LEN_MAX) begin
        token_length_next = token_length + 3'd1;
      end
    end
    byte_position_next = (byte_position < POS_MAX) ? byte_position + 4'd1 : byte_position;
  end

  assign verdict = method_found_next && token_present_next && !token_at_start_next &&
                   (token_length_next > VERSION_LEN) && token_prefix_ok_next;

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      byte_position      <= '0;
      method_candidates  <= ALL_METHODS;
      method_found       <= 1'b0;
      token_present      <= 1'b0;
      token_at_start     <= 1'b0;
      token_length       <= '0;
      token_prefix_ok    <= 1'b0;
      previous_was_space <= 1'b1;
    end else if (step) begin
      byte_position      <= byte_position_next;
      method_candidates  <= method_candidates_next;
      method_found       <= method_found_next;
      token_present      <= token_present_next;
      token_at_start     <= token_at_start_next;
      token_length       <= token_length_next;
      token_prefix_ok    <= token_prefix_ok_next;
      previous_was_space <= previous_was_space_next;
    end
  end

endmodule

[hw/rtl/hrld_checker.sv]
// Port-level checker for the HTTP request line detector, with its bind statement.
// Counts lines in flight and checks the output handshake and flow control.
// Depends on http_request_line_detector.
`timescale 1ns / 1ps

module hrld_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       last_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       is_request_line
);

  logic [1:0] pending;
  logic       line_in;
  logic       line_out;

  assign line_in  = in_valid && in_ready && last_byte;
  assign line_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (line_in && !line_out) begin
      pending <= pending + 2'd1;
    end else if (line_out && !line_in) begin
      pending <= pending - 2'd1;
    end
  end

  // A held verdict stays until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_request_line))
    else $error("verdict dropped or changed while stalled");

  // No verdict without a finished line waiting for it.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("verdict without a completed line");

  // At most two lines can be in flight: one in each register.
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many lines in flight");

  // The block never stalls its input while the output side can move.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled while output is free");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind http_request_line_detector hrld_checker u_hrld_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .last_byte       (last_byte),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .is_request_line (is_request_line)
);

[dv/http_request_line_detector_tb.sv]
// Testbench for http_request_line_detector: drives byte transactions under random
// idling and back-pressure, and checks each line verdict against its own line scanner.
// Depends on hrld_pkg and the http_request_line_detector RTL.
`timescale 1ns / 1ps

module http_request_line_detector_tb import hrld_pkg::*; ();

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_BYTES   = 1950;
  localparam int IDLE_PERCENT   = 18;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_LIMIT   = 10;

  // Scores verdicts. It keeps a line scanner of its own that follows every
  // accepted byte transaction and queues the verdict due at the end of a line.
  class verdict_scoreboard;
    logic [POS_W-1:0]        position;
    logic [METHOD_COUNT-1:0] candidates;
    bit                      method_seen;
    bit                      token_seen;
    bit                      token_first;
    logic [TLEN_W-1:0]       token_len;
    bit                      token_http;
    bit                      prev_ws;
    bit                      expected_verdicts[$];
    int                      mismatches;
    int                      stray_verdicts;

    function new();
      mismatches = 0;
      stray_verdicts = 0;
      start_line();
    endfunction

    function void start_line();
      position    = '0;
      candidates  = ALL_METHODS;
      method_seen = 1'b0;
      token_seen  = 1'b0;
      token_first = 1'b0;
      token_len   = '0;
      token_http  = 1'b0;
      prev_ws     = 1'b1;
    endfunction

    // Advances the scanner by one accepted byte; on the last byte of a line
    // the verdict goes to the back of the queue and the scanner starts over.
    function void note_byte(logic [7:0] b, logic last);
      bit ws;
      ws = (b == CHAR_TAB) || (b == CHAR_SPACE);
      for (int m = 0; m < METHOD_COUNT; m++) begin
        if (candidates[m]) begin
          if (position < METHOD_LEN[m]) begin
            if (b != METHOD_TEXT[m][position[2:0]]) candidates[m] = 1'b0;
          end else begin
            // A method counts only when whitespace follows it directly.
            if (position == METHOD_LEN[m] && ws) method_seen = 1'b1;
            candidates[m] = 1'b0;
          end
        end
      end
      if (ws) begin
        prev_ws = 1'b1;
      end else if (prev_ws) begin
        prev_ws     = 1'b0;
        token_seen  = 1'b1;
        token_first = (position == 0);
        token_len   = 3'd1;
        token_http  = (b == VERSION_TEXT[0]);
      end else begin
        if (token_len < VERSION_LEN)
          token_http = token_http && (b == VERSION_TEXT[token_len]);
        if (token_len < TOKEN_LEN_MAX) token_len = token_len + 3'd1;
      end
      if (position < POS_MAX) position = position + 4'd1;
      if (last) begin
        expected_verdicts.push_back(method_seen && token_seen && !token_first &&
                                    token_len > VERSION_LEN && token_http);
        start_line();
      end
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (expected_verdicts.size() == 0) begin
        stray_verdicts++;
        if (mismatches + stray_verdicts <= REPORT_LIMIT)
          $display("%0t: verdict %b arrived with no line pending", $time, got);
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches + stray_verdicts <= REPORT_LIMIT)
            $display("%0t: is_request_line expected %b, got %b", $time, want, got);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] line_byte = 8'd0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       is_request_line;

  verdict_scoreboard sb = new();

  // Knobs shared between the stimulus and the receiver, the watchdog count and the line buffer.
  bit          no_idle = 1'b0;
  int          hold_requests = 0;
  int          cycle_count = 0;
  logic [7:0]  line_q[$];

  http_request_line_detector dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .line_byte       (line_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .is_request_line (is_request_line)
  );

  always #CLK_HALF clk = ~clk;

  // Both monitors sample at the rising edge, before any driver update of that
  // edge takes effect, so each handshake is seen exactly as the block saw it.
  // A verdict cannot leave in the same cycle its byte arrives, so the order of
  // the two calls does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(line_byte, last_byte);
      if (out_valid && out_ready) sb.check_verdict(is_request_line);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("http_request_line_detector verification failed");
      $finish;
    end
  end

  // Receiver. It stalls at random, never during the no-idle stretch, and on
  // request holds out_ready low for a long run that it counts itself. During
  // that run the sender keeps offering bytes, so the block fills and stops
  // accepting transactions.
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Offers one byte and returns at the edge where it is taken. The valid stays
  // high on return, so a following byte goes out back to back unless the next
  // call decides to idle first.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    line_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_ws();
    return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
  endfunction

  function automatic logic [7:0] rand_token_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_TAB || b == CHAR_SPACE);
    return b;
  endfunction

  function automatic void add_ws(int lo, int hi);
    repeat ($urandom_range(lo, hi)) line_q.push_back(rand_ws());
  endfunction

  function automatic void add_word(int lo, int hi);
    repeat ($urandom_range(lo, hi)) line_q.push_back(rand_token_byte());
  endfunction

  // Pushes a method name; when damaged, one letter changes case or is replaced,
  // and sometimes the name is also cut short after that letter.
  function automatic void add_method(int m, bit damage);
    int len;
    int spot;
    len = int'(METHOD_LEN[m]);
    spot = $urandom_range(0, len - 1);
    if (damage && $urandom_range(0, 2) == 0) len = spot + 1;
    for (int k = 0; k < len; k++) begin
      if (damage && k == spot) begin
        if ($urandom_range(0, 1)) line_q.push_back(METHOD_TEXT[m][k] ^ 8'h20);
        else line_q.push_back(rand_token_byte());
      end else begin
        line_q.push_back(METHOD_TEXT[m][k]);
      end
    end
  endfunction

  // Version token: the HTTP/ prefix, sometimes with one byte spoiled, followed
  // by zero to four bytes, so the token runs from exactly five bytes upward.
  function automatic void add_version();
    int spoil;
    spoil = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : -1;
    for (int k = 0; k < 5; k++) begin
      if (k == spoil) line_q.push_back(rand_token_byte());
      else line_q.push_back(VERSION_TEXT[k]);
    end
    add_word(0, 4);
  endfunction

  function automatic void build_random_line();
    int kind;
    int m;
    kind = $urandom_range(0, 99);
    m = $urandom_range(0, METHOD_COUNT - 1);
    line_q.delete();
    if (kind < 65) begin
      // Well-formed shape with random content; extra middle tokens also make
      // lines long enough to saturate the byte position.
      add_method(m, 1'b0);
      add_ws(1, 2);
      repeat ($urandom_range(0, 2)) begin
        add_word(1, 6);
        add_ws(1, 2);
      end
      add_version();
      if ($urandom_range(0, 9) == 0) begin
        add_ws(1, 1);
        add_word(1, 4);
      end
      add_ws(0, 2);
    end else if (kind < 78) begin
      // Damaged method, or a method run straight into the next token.
      if ($urandom_range(0, 1)) begin
        add_method(m, 1'b1);
        add_ws(1, 2);
      end else begin
        add_method(m, 1'b0);
        add_word(1, 3);
        add_ws(1, 1);
      end
      add_version();
      add_ws(0, 1);
    end else if (kind < 86) begin
      // Line ending at the method or just after its whitespace.
      add_method(m, 1'b0);
      add_ws(0, 2);
    end else if (kind < 92) begin
      // Version token with no method in front of it.
      add_ws(0, 1);
      add_version();
      add_ws(0, 2);
    end else begin
      repeat ($urandom_range(1, 24))
        line_q.push_back($urandom_range(0, 3) == 0 ? rand_ws() : 8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    int random_bytes;
    int line_count;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines: a method with nothing after it, the byte extremes as
    // one-byte lines, a whitespace-only line, a good line with a tab and a
    // trailing space, and a version token of exactly five bytes.
    line_q.delete();
    push_text("PUT");
    send_line();
    line_q = '{8'hFF};
    send_line();
    line_q = '{8'h00};
    send_line();
    line_q.delete();
    push_text("\t \t");
    send_line();
    line_q.delete();
    push_text("GET\tHTTP/1 ");
    send_line();
    line_q.delete();
    push_text("HEAD HTTP/");
    send_line();

    random_bytes = 0;
    line_count = 0;
    while (random_bytes < RANDOM_BYTES) begin
      // The sender waits for every outstanding verdict once, with valid low.
      if (line_count == 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_verdicts.size() != 0) @(posedge clk);
      end
      if (line_count == 30) hold_requests++;
      no_idle = (line_count >= 50 && line_count < 80);
      build_random_line();
      send_line();
      random_bytes += line_q.size();
      line_count++;
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.stray_verdicts == 0 && sb.expected_verdicts.size() == 0) begin
      $display("http_request_line_detector verification clean");
    end else begin
      $display("http_request_line_detector verification failed");
    end
    $finish;
  end

endmodule
